@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ design/cact_pkg.sv @@
// Package of the class argmax centroid tracker: field widths, divider widths,
// register index codes. No dependencies.
package cact_pkg;

  localparam int ScoreW  = 16;
  localparam int ClassW  = 6;
  localparam int XW      = 10;
  localparam int YW      = 9;
  localparam int WidthW  = 11;
  localparam int HeightW = 10;
  localparam int CountW  = 20;
  localparam int SumXW   = 29;
  localparam int SumYW   = 28;
  localparam int Q16W    = 16;
  localparam int DenW    = CountW + WidthW;   // largest divisor: count * width
  localparam int SubW    = DenW + 2;          // shared subtractor, borrow on top
  localparam int StepW   = 4;                 // counts the 16 quotient bits
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 11;

  localparam logic [Q16W-1:0] Q16Max = '1;

  localparam logic [CfgIdxW-1:0] CfgTargetClass = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd2;

endpackage

@@ design/class_argmax_centroid_tracker.sv @@
// Top level of the class argmax centroid tracker.
// Depends on cact_pkg.
//
// Scores stream in one class channel per request. A request that does not end
// a frame is absorbed in the cycle it is accepted, so such requests can flow
// one per cycle: the running argmax and the target-class accumulators (count,
// sum of x, sum of y, all saturating) update at the accepting edge. The
// request that carries last_of_frame starts the frame-end sequencer and drops
// in_ready until the result is loaded into the output register. The sequencer
// works out three Q0.16 ratios (area, center x, center y) one after another on
// a single shared multiplier and a single shared 33-bit compare/subtract unit
// running a restoring divider: per ratio, S_MUL registers the divisor,
// S_DIV_INIT checks for saturation (numerator not below the divisor caps at
// 65535; a center with a zero count gives zero) and, when neither applies,
// S_DIV_STEP develops the sixteen quotient bits, one per cycle. The sequencer
// waits in S_DONE until the previous result is taken. The result sits in an
// output register, so a new frame can stream in while it waits. A frame width
// or height of zero counts as one. Configuration writes are always accepted
// and must only be issued while the block is idle.
module class_argmax_centroid_tracker
  import cact_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 512,
  parameter int MAX_CLASSES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgDataW-1:0]       cfg_data,
  // score requests
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ScoreW-1:0]  in_score,
  input  logic [ClassW-1:0]         in_channel,
  input  logic [XW-1:0]             in_pixel_x,
  input  logic [YW-1:0]             in_pixel_y,
  input  logic                      in_last_channel,
  input  logic                      in_last_of_frame,
  // frame results
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_detected,
  output logic [Q16W-1:0]           out_area,
  output logic [Q16W-1:0]           out_center_x,
  output logic [Q16W-1:0]           out_center_y
);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_DIV_INIT = 3'd2;
  localparam logic [2:0] S_DIV_STEP = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  // which ratio the shared unit is working on
  localparam logic [1:0] OP_AREA = 2'd0;
  localparam logic [1:0] OP_CX   = 2'd1;
  localparam logic [1:0] OP_CY   = 2'd2;

  localparam logic [StepW-1:0] LastStep = '1;

  // configuration registers
  logic [ClassW-1:0]        target_r;
  logic [WidthW-1:0]        width_r;
  logic [HeightW-1:0]       height_r;

  // running argmax and accumulators
  logic signed [ScoreW-1:0] best_score_r;
  logic [ClassW-1:0]        best_class_r;
  logic [CountW-1:0]        count_r;
  logic [SumXW-1:0]         sum_x_r;
  logic [SumYW-1:0]         sum_y_r;

  // sequencer and shared divider
  logic [2:0]               state_r;
  logic [1:0]               op_r;
  logic [StepW-1:0]         step_r;
  logic [DenW-1:0]          den_r;
  logic [DenW-1:0]          rem_r;
  logic [Q16W-1:0]          quo_r;
  logic [Q16W-1:0]          area_q_r;
  logic [Q16W-1:0]          cx_q_r;
  logic [Q16W-1:0]          cy_q_r;

  // output register
  logic                     out_valid_r;
  logic                     out_detected_r;
  logic [Q16W-1:0]          out_area_r;
  logic [Q16W-1:0]          out_center_x_r;
  logic [Q16W-1:0]          out_center_y_r;

  logic                     in_accept;
  logic                     chan_ok;
  logic                     take_new;
  logic [ClassW-1:0]        best_class_nxt;
  logic                     hit;
  logic [CountW:0]          count_add;
  logic [SumXW:0]           sum_x_add;
  logic [SumYW:0]           sum_y_add;
  logic [CountW-1:0]        count_sat;
  logic [SumXW-1:0]         sum_x_sat;
  logic [SumYW-1:0]         sum_y_sat;

  logic [WidthW-1:0]        w_eff;
  logic [HeightW-1:0]       h_eff;
  logic [CountW-1:0]        mul_a;
  logic [WidthW-1:0]        mul_b;
  logic [DenW-1:0]          mul_p;
  logic [SubW-1:0]          num;
  logic [SubW-1:0]          sub_a;
  logic [SubW-1:0]          sub_diff;
  logic                     borrow;
  logic [Q16W-1:0]          quo_nxt;
  logic                     res_we;
  logic [Q16W-1:0]          res_val;
  logic                     load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // Argmax: channel 0 always reseeds, later channels win only on strictly
  // greater, out-of-range channels leave the running best alone.
  assign chan_ok  = (32'(in_channel) < 32'(MAX_CLASSES));
  assign take_new = chan_ok && ((in_channel == '0) || (in_score > best_score_r));
  assign best_class_nxt = take_new ? in_channel : best_class_r;
  assign hit = in_last_channel && (best_class_nxt == target_r);

  // Saturating accumulators: hold at all ones on carry out.
  assign count_add = {1'b0, count_r} + (CountW+1)'(1);
  assign sum_x_add = {1'b0, sum_x_r} + (SumXW+1)'(in_pixel_x);
  assign sum_y_add = {1'b0, sum_y_r} + (SumYW+1)'(in_pixel_y);
  assign count_sat = count_add[CountW] ? '1 : count_add[CountW-1:0];
  assign sum_x_sat = sum_x_add[SumXW] ? '1 : sum_x_add[SumXW-1:0];
  assign sum_y_sat = sum_y_add[SumYW] ? '1 : sum_y_add[SumYW-1:0];

  assign w_eff = (width_r == '0) ? WidthW'(1) : width_r;
  assign h_eff = (height_r == '0) ? HeightW'(1) : height_r;

  // Shared multiplier: forms the divisor of the current ratio.
  always_comb begin
    case (op_r)
      OP_AREA: begin
        mul_a = CountW'(w_eff);
        mul_b = WidthW'(h_eff);
      end
      OP_CX: begin
        mul_a = count_r;
        mul_b = w_eff;
      end
      default: begin
        mul_a = count_r;
        mul_b = WidthW'(h_eff);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Numerator of the current ratio.
  always_comb begin
    case (op_r)
      OP_AREA: num = SubW'(count_r);
      OP_CX:   num = SubW'(sum_x_r);
      default: num = SubW'(sum_y_r);
    endcase
  end

  // Shared compare/subtract: saturation check first, then one quotient bit
  // per cycle on the doubled remainder.
  assign sub_a    = (state_r == S_DIV_STEP) ? {1'b0, rem_r, 1'b0} : num;
  assign sub_diff = sub_a - SubW'(den_r);
  assign borrow   = sub_diff[SubW-1];
  assign quo_nxt  = {quo_r[Q16W-2:0], ~borrow};

  // Finished ratio value and its write strobe.
  always_comb begin
    res_we  = 1'b0;
    res_val = quo_nxt;
    case (state_r)
      S_DIV_INIT: begin
        if ((op_r != OP_AREA) && (count_r == '0)) begin
          res_we  = 1'b1;
          res_val = '0;
        end else if (!borrow) begin
          res_we  = 1'b1;
          res_val = Q16Max;
        end
      end
      S_DIV_STEP: res_we = (step_r == LastStep);
      default: res_we = 1'b0;
    endcase
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      width_r      <= WidthW'(MAX_WIDTH);
      height_r     <= HeightW'(MAX_HEIGHT);
      best_score_r <= '0;
      best_class_r <= '0;
      count_r      <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      state_r      <= S_IDLE;
      op_r         <= OP_AREA;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CfgTargetClass: target_r <= cfg_data[ClassW-1:0];
          CfgFrameWidth:  width_r  <= cfg_data[WidthW-1:0];
          CfgFrameHeight: height_r <= cfg_data[HeightW-1:0];
          default: ;
        endcase
      end

      if (in_accept && take_new) begin
        best_score_r <= in_score;
        best_class_r <= in_channel;
      end

      if (in_accept && hit) begin
        count_r <= count_sat;
        sum_x_r <= sum_x_sat;
        sum_y_r <= sum_y_sat;
      end

      // Drop the taken result unless a new one replaces it in the same cycle.
      if (out_valid_r && out_ready && !load_out) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept && in_last_of_frame) begin
            op_r    <= OP_AREA;
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_DIV_INIT;
        S_DIV_INIT: begin
          step_r <= '0;
          if (!res_we) begin
            state_r <= S_DIV_STEP;
          end
        end
        S_DIV_STEP: begin
          step_r <= step_r + StepW'(1);
        end
        S_DONE: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            count_r     <= '0;
            sum_x_r     <= '0;
            sum_y_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Advance to the next ratio, or finish after center y.
      if (res_we) begin
        if (op_r == OP_CY) begin
          state_r <= S_DONE;
        end else begin
          op_r    <= op_r + 2'd1;
          state_r <= S_MUL;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      den_r <= mul_p;
    end
    if (state_r == S_DIV_INIT) begin
      rem_r <= num[DenW-1:0];
      quo_r <= '0;
    end else if (state_r == S_DIV_STEP) begin
      rem_r <= borrow ? sub_a[DenW-1:0] : sub_diff[DenW-1:0];
      quo_r <= quo_nxt;
    end
    if (res_we) begin
      case (op_r)
        OP_AREA: area_q_r <= res_val;
        OP_CX:   cx_q_r   <= res_val;
        default: cy_q_r   <= res_val;
      endcase
    end
    if (load_out) begin
      out_detected_r <= (count_r != '0);
      out_area_r     <= area_q_r;
      out_center_x_r <= cx_q_r;
      out_center_y_r <= cy_q_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_detected = out_detected_r;
  assign out_area     = out_area_r;
  assign out_center_x = out_center_x_r;
  assign out_center_y = out_center_y_r;

endmodule

@@ design/cact_checker.sv @@
// Port-level checker for the class argmax centroid tracker, bound to the top.
// Depends on cact_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cact_checker
  import cact_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last_of_frame,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_detected,
  input logic [Q16W-1:0]           out_area,
  input logic [Q16W-1:0]           out_center_x,
  input logic [Q16W-1:0]           out_center_y
);

  logic                in_take;
  logic                out_all_zero;
  logic [3*Q16W:0]     out_bits;

  assign in_take      = in_valid && in_ready;
  assign out_all_zero = (out_area == '0) && (out_center_x == '0) && (out_center_y == '0);
  assign out_bits     = {out_detected, out_area, out_center_x, out_center_y};

  // An empty mask reports zero area and a zero center.
  `ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && !out_detected, out_all_zero)

  // Mid-frame requests never stall the stream.
  `ASSERT_NEXT(a_stream_ready, clk, rst_n, in_take && !in_last_of_frame, in_ready)

  // A frame end hands off to the sequencer.
  `ASSERT_NEXT(a_frame_busy, clk, rst_n, in_take && in_last_of_frame, !in_ready)

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bits))

endmodule

bind class_argmax_centroid_tracker cact_checker u_cact_checker (.*);
